// ===== design/uigf_pkg.sv =====
// ----------------------------------------------------------------------------
// uigf_pkg
// Shared types, constants and a helper for the UART idle-gap framer and
// transmit sequencer.
// ----------------------------------------------------------------------------
package uigf_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] RX_BUFFER_BYTES = 16'd256;
  localparam logic [CFG_W-1:0] TX_BUFFER_BYTES = 16'd256;
  localparam logic [CFG_W-1:0] RX_GAP_RESET    = 16'd100;
  localparam logic [CFG_W-1:0] TX_GUARD_RESET  = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_RX_GAP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TX_GUARD = 1'b1;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    TX_IDLE  = 3'b001,
    TX_BUSY  = 3'b010,
    TX_GUARD = 3'b100
  } tx_state_t;

  typedef enum logic [2:0] {
    RX_ARM   = 3'b001,
    RX_WAIT  = 3'b010,
    RX_FRAME = 3'b100
  } rx_state_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] start_len;
    logic             pending;
  } tx_res_t;

  typedef struct packed {
    logic             arm;
    logic             ready;
    logic [LEN_W-1:0] length;
  } rx_res_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [CFG_W-1:0] limit);
    logic [LEN_W-1:0] res;
    res = v;
    if ({{(CFG_W-LEN_W){1'b0}}, v} > limit) res = limit[LEN_W-1:0];
    return res;
  endfunction

endpackage

// ===== design/uart_idle_gap_framer_tx_sequencer.sv =====
// ----------------------------------------------------------------------------
// uart_idle_gap_framer_tx_sequencer
// Each input word is one status poll; each poll yields one result word. A poll
// is registered on entry, runs once through the transmit and receive state
// machines and lands in the output register, so one word per cycle is
// sustained while the output is not stalled; the input register can take the
// next poll while a result still waits downstream.
// ----------------------------------------------------------------------------
module uart_idle_gap_framer_tx_sequencer
  import uigf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // now_us[31:0], rx_count[40:32], rx_channel_enabled[41], tx_request[42],
  // tx_length[51:43], tx_transfer_done[52], rx_release[53], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tx_start[0], tx_start_length[9:1], tx_pending[10], rx_arm[11],
  // frame_ready[12], frame_length[21:13], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic                   in_vld_r;
  logic [IN_TDATA_W-1:0]  in_data_r;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [CFG_W-1:0]       rx_gap_r;
  logic [CFG_W-1:0]       tx_guard_r;
  logic                   step;
  tx_res_t                tx_res;
  rx_res_t                rx_res;
  logic [LEN_W-1:0]       rx_count_c;
  logic [LEN_W-1:0]       tx_length_c;

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  assign rx_count_c  = clamp_len(in_data_r[40:32], RX_BUFFER_BYTES);
  assign tx_length_c = clamp_len(in_data_r[51:43], TX_BUFFER_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_gap_r   <= RX_GAP_RESET;
      tx_guard_r <= TX_GUARD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RX_GAP:   rx_gap_r   <= cfg_wdata;
        REG_TX_GUARD: tx_guard_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_data_r <= in_tdata;
  end

  uigf_tx_fsm u_tx (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .now_us           (in_data_r[31:0]),
    .tx_request       (in_data_r[42]),
    .tx_length        (tx_length_c),
    .tx_transfer_done (in_data_r[52]),
    .tx_guard_us      (tx_guard_r),
    .res              (tx_res)
  );

  uigf_rx_fsm u_rx (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (step),
    .now_us             (in_data_r[31:0]),
    .rx_count           (rx_count_c),
    .rx_channel_enabled (in_data_r[41]),
    .rx_release         (in_data_r[53]),
    .rx_gap_us          (rx_gap_r),
    .res                (rx_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {2'b00, rx_res.length, rx_res.ready, rx_res.arm,
                     tx_res.pending, tx_res.start_len, tx_res.start};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/uigf_tx_fsm.sv =====
// ----------------------------------------------------------------------------
// uigf_tx_fsm
// Transmit sequencer: latch requests, drop empty ones, pulse start, wait for
// completion, then hold off for the guard time.
// ----------------------------------------------------------------------------
module uigf_tx_fsm
  import uigf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [TIME_W-1:0] now_us,
  input  logic              tx_request,
  input  logic [LEN_W-1:0]  tx_length,
  input  logic              tx_transfer_done,
  input  logic [CFG_W-1:0]  tx_guard_us,
  output tx_res_t           res
);

  tx_state_t         state_r, state_nxt;
  logic              lat_r, lat_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [TIME_W-1:0] mark_r, mark_nxt;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_us - mark_r;

  always_comb begin
    state_nxt     = state_r;
    lat_nxt       = tx_request ? 1'b1 : lat_r;
    len_nxt       = tx_request ? tx_length : len_r;
    mark_nxt      = mark_r;
    res.start     = 1'b0;
    res.start_len = '0;
    unique case (state_r)
      TX_IDLE: begin
        if (lat_nxt) begin
          if (len_nxt == '0) begin
            lat_nxt = 1'b0;
          end else begin
            res.start     = 1'b1;
            res.start_len = len_nxt;
            state_nxt     = TX_BUSY;
          end
        end
      end
      TX_BUSY: begin
        if (tx_transfer_done) begin
          lat_nxt   = 1'b0;
          mark_nxt  = now_us;
          state_nxt = TX_GUARD;
        end
      end
      TX_GUARD: begin
        if (elapsed > {{(TIME_W-CFG_W){1'b0}}, tx_guard_us}) state_nxt = TX_IDLE;
      end
      default: state_nxt = TX_IDLE;
    endcase
    res.pending = lat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TX_IDLE;
      lat_r   <= 1'b0;
      len_r   <= '0;
      mark_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      lat_r   <= lat_nxt;
      len_r   <= len_nxt;
      mark_r  <= mark_nxt;
    end
  end

endmodule

// ===== design/uigf_rx_fsm.sv =====
// ----------------------------------------------------------------------------
// uigf_rx_fsm
// Receive framer: arm reception, time the silence after the last byte count
// change and latch the frame length once the gap is exceeded.
// ----------------------------------------------------------------------------
module uigf_rx_fsm
  import uigf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [TIME_W-1:0] now_us,
  input  logic [LEN_W-1:0]  rx_count,
  input  logic              rx_channel_enabled,
  input  logic              rx_release,
  input  logic [CFG_W-1:0]  rx_gap_us,
  output rx_res_t           res
);

  rx_state_t         state_r, state_nxt;
  logic              ready_r, ready_nxt;
  logic [LEN_W-1:0]  last_r, last_nxt;
  logic [LEN_W-1:0]  flen_r, flen_nxt;
  logic [TIME_W-1:0] mark_r, mark_nxt;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_us - mark_r;

  always_comb begin
    state_nxt = state_r;
    ready_nxt = rx_release ? 1'b0 : ready_r;
    last_nxt  = last_r;
    flen_nxt  = flen_r;
    mark_nxt  = mark_r;
    res.arm   = 1'b0;
    unique case (state_r)
      RX_ARM: begin
        if (!ready_nxt) begin
          res.arm   = 1'b1;
          state_nxt = RX_WAIT;
        end
      end
      RX_WAIT: begin
        if (rx_count != '0) begin
          last_nxt  = rx_count;
          mark_nxt  = now_us;
          state_nxt = RX_FRAME;
        end else if (!rx_channel_enabled) begin
          ready_nxt = 1'b0;
          state_nxt = RX_ARM;
        end
      end
      RX_FRAME: begin
        if (rx_count != last_r) begin
          mark_nxt = now_us;
          last_nxt = rx_count;
        end else if (elapsed > {{(TIME_W-CFG_W){1'b0}}, rx_gap_us}) begin
          flen_nxt  = last_r;
          ready_nxt = 1'b1;
          state_nxt = RX_ARM;
        end
      end
      default: state_nxt = RX_ARM;
    endcase
    res.ready  = ready_nxt;
    res.length = flen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RX_ARM;
      ready_r <= 1'b0;
      last_r  <= '0;
      flen_r  <= '0;
      mark_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      last_r  <= last_nxt;
      flen_r  <= flen_nxt;
      mark_r  <= mark_nxt;
    end
  end

endmodule

// ===== design/uigf_checker.sv =====
// ----------------------------------------------------------------------------
// uigf_checker
// Port-level checks on the result stream of the framer and sequencer.
// ----------------------------------------------------------------------------
module uigf_checker
  import uigf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[9:1] != '0)
    else $error("start issued with zero length");

  a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[9:1] == '0)
    else $error("start length without start");

  a_start_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[10])
    else $error("start without pending request");

  a_arm_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> !out_tdata[12])
    else $error("rearm while frame still ready");

endmodule

bind uart_idle_gap_framer_tx_sequencer uigf_checker u_uigf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/uart_idle_gap_framer_tx_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_idle_gap_framer_tx_sequencer_tb
// Self-checking bench for the idle-gap framer and transmit sequencer. Status
// polls are streamed in with a running microsecond clock and a plausible
// receive count. An in-bench model of both state machines predicts each
// status word. Each status word that comes out is compared field by field.
// ----------------------------------------------------------------------------
module uart_idle_gap_framer_tx_sequencer_tb;
  import uigf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic [LEN_W-1:0]  rx_count;
    logic              rx_channel_enabled;
    logic              tx_request;
    logic [LEN_W-1:0]  tx_length;
    logic              tx_transfer_done;
    logic              rx_release;
  } poll_t;

  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic             frame_ready;
    logic             rx_arm;
    logic             tx_pending;
    logic [LEN_W-1:0] tx_start_length;
    logic             tx_start;
  } status_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // now_us[31:0], rx_count[40:32], rx_channel_enabled[41], tx_request[42],
  // tx_length[51:43], tx_transfer_done[52], rx_release[53], zero fill
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // tx_start[0], tx_start_length[9:1], tx_pending[10], rx_arm[11],
  // frame_ready[12], frame_length[21:13], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  uart_idle_gap_framer_tx_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  int mismatches = 0;
  int idle_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  status_t expected_status[$];

  // stimulus-side view of the line
  logic [TIME_W-1:0] clock_us = '0;
  int                line_count = 0;

  // model state
  logic [CFG_W-1:0]  gap_us = RX_GAP_RESET;
  logic [CFG_W-1:0]  guard_us = TX_GUARD_RESET;
  tx_state_t         tx_state = TX_IDLE;
  rx_state_t         rx_state = RX_ARM;
  logic              req_held = 1'b0;
  logic [LEN_W-1:0]  len_held = '0;
  logic [TIME_W-1:0] tx_mark = '0;
  logic [TIME_W-1:0] rx_mark = '0;
  logic [LEN_W-1:0]  last_count = '0;
  logic              ready_flag = 1'b0;
  logic [LEN_W-1:0]  frame_len = '0;
  status_t           last_status = '0;

  function automatic poll_t mk_poll(input logic [TIME_W-1:0] now, input int cnt,
                                    input bit en, input bit req, input int len,
                                    input bit done, input bit rel);
    poll_t p;
    p.now_us             = now;
    p.rx_count           = cnt[LEN_W-1:0];
    p.rx_channel_enabled = en;
    p.tx_request         = req;
    p.tx_length          = len[LEN_W-1:0];
    p.tx_transfer_done   = done;
    p.rx_release         = rel;
    return p;
  endfunction

  task automatic predict_status(input poll_t p);
    status_t          s;
    logic [LEN_W-1:0] cnt;
    logic [LEN_W-1:0] len;
    logic [TIME_W-1:0] elapsed;
    s = '0;
    cnt = ({7'd0, p.rx_count} > RX_BUFFER_BYTES) ? RX_BUFFER_BYTES[LEN_W-1:0] : p.rx_count;
    len = ({7'd0, p.tx_length} > TX_BUFFER_BYTES) ? TX_BUFFER_BYTES[LEN_W-1:0] : p.tx_length;

    if (p.rx_release) ready_flag = 1'b0;
    if (p.tx_request) begin
      req_held = 1'b1;
      len_held = len;
    end

    case (tx_state)
      TX_IDLE: begin
        if (req_held) begin
          if (len_held == '0) begin
            req_held = 1'b0;
          end else begin
            s.tx_start = 1'b1;
            s.tx_start_length = len_held;
            tx_state = TX_BUSY;
          end
        end
      end
      TX_BUSY: begin
        if (p.tx_transfer_done) begin
          req_held = 1'b0;
          tx_mark = p.now_us;
          tx_state = TX_GUARD;
        end
      end
      TX_GUARD: begin
        elapsed = p.now_us - tx_mark;
        if (elapsed > {16'd0, guard_us}) tx_state = TX_IDLE;
      end
      default: tx_state = TX_IDLE;
    endcase

    case (rx_state)
      RX_ARM: begin
        if (!ready_flag) begin
          s.rx_arm = 1'b1;
          rx_state = RX_WAIT;
        end
      end
      RX_WAIT: begin
        if (cnt != '0) begin
          last_count = cnt;
          rx_mark = p.now_us;
          rx_state = RX_FRAME;
        end else if (!p.rx_channel_enabled) begin
          ready_flag = 1'b0;
          rx_state = RX_ARM;
        end
      end
      RX_FRAME: begin
        elapsed = p.now_us - rx_mark;
        if (cnt != last_count) begin
          rx_mark = p.now_us;
          last_count = cnt;
        end else if (elapsed > {16'd0, gap_us}) begin
          frame_len = last_count;
          ready_flag = 1'b1;
          rx_state = RX_ARM;
        end
      end
      default: rx_state = RX_ARM;
    endcase

    s.tx_pending = req_held;
    s.frame_ready = ready_flag;
    s.frame_length = frame_len;
    last_status = s;
    expected_status.push_back(s);
  endtask

  task automatic send_poll(input poll_t p);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {2'b00, p.rx_release, p.tx_transfer_done, p.tx_length, p.tx_request,
                 p.rx_channel_enabled, p.rx_count, p.now_us};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_status(p);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RX_GAP:   gap_us = val;
      REG_TX_GUARD: guard_us = val;
      default: ;
    endcase
  endtask

  // random polls with a running clock and a receive count that restarts after each arm and then grows
  task automatic run_traffic(input int n_polls, input int step_max);
    poll_t p;
    int    len;
    for (int i = 0; i < n_polls; i++) begin
      if ($urandom_range(49) == 0) clock_us = $urandom;
      else clock_us = clock_us + $urandom_range(step_max);
      if (line_count < 256 && $urandom_range(99) < 25) begin
        line_count = line_count + $urandom_range(1, 4);
        if (line_count > 256) line_count = 256;
      end
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = $urandom_range(257, 511);
        default: len = $urandom_range(1, 256);
      endcase
      p = mk_poll(clock_us, line_count, $urandom_range(9) != 0, $urandom_range(99) < 15,
                  len, $urandom_range(99) < (last_status.tx_pending ? 30 : 5),
                  $urandom_range(99) < (last_status.frame_ready ? 25 : 3));
      if ($urandom_range(24) == 0) p.rx_count = LEN_W'($urandom_range(511));
      send_poll(p);
      if (last_status.rx_arm) line_count = 0;
    end
  endtask

  task automatic test_special_cases();
    gap_pct = 0;
    stall_pct = 0;
    send_poll(mk_poll(32'd0,   0,   1, 0, 0,   0, 0));
    send_poll(mk_poll(32'd10,  5,   1, 0, 0,   0, 0));
    // zero-length request, count restarts the gap timer
    send_poll(mk_poll(32'd50,  9,   1, 1, 0,   0, 0));
    send_poll(mk_poll(32'd160, 9,   1, 0, 0,   0, 0));
    // oversize transmit length
    send_poll(mk_poll(32'd170, 0,   1, 1, 511, 0, 0));
    // request while busy, then completion drops it
    send_poll(mk_poll(32'd180, 0,   1, 1, 7,   0, 1));
    send_poll(mk_poll(32'd190, 0,   0, 0, 0,   1, 0));
    // release with no frame pending
    send_poll(mk_poll(32'd250, 0,   1, 0, 0,   0, 1));
    send_poll(mk_poll(32'd290, 0,   1, 1, 3,   0, 0));
    send_poll(mk_poll(32'd291, 0,   1, 0, 0,   0, 0));
    send_poll(mk_poll(32'd292, 0,   1, 1, 256, 0, 0));
    // oversize receive count
    send_poll(mk_poll(32'd300, 511, 1, 0, 0,   1, 0));
    // gap timer across the clock wrap
    send_poll(mk_poll(32'hFFFF_FFF0, 200, 1, 0, 0, 0, 0));
    send_poll(mk_poll(32'h0000_0050, 200, 1, 0, 0, 0, 0));
    send_poll(mk_poll(32'h0000_0075, 200, 1, 0, 0, 0, 0));
    send_poll(mk_poll(32'h0000_0080, 0,   1, 1, 1, 0, 1));
    send_poll(mk_poll(32'h0000_0090, 0,   1, 0, 0, 1, 0));
    send_poll(mk_poll(32'hFFFF_FFFF, 0,   1, 0, 0, 0, 0));
    send_poll(mk_poll(32'hFFFF_FFFF, 1,   1, 1, 255, 1, 1));
    send_poll(mk_poll(32'h5555_AAAA, 256, 0, 1, 256, 0, 1));
    wait_idle();
    line_count = 0;
  endtask

  task automatic test_window_extremes();
    write_reg(REG_RX_GAP, 16'd0);
    write_reg(REG_TX_GUARD, 16'd0);
    run_traffic(100, 3);
    wait_idle();
    gap_pct = 7;
    stall_pct = 7;
    write_reg(REG_RX_GAP, 16'hFFFF);
    write_reg(REG_TX_GUARD, 16'hFFFF);
    run_traffic(100, 20000);
    wait_idle();
  endtask

  task automatic test_idle_patterns();
    int gap_mode[4]   = '{0, 85, 0, 7};
    int stall_mode[4] = '{0, 0, 85, 7};
    int gap_cfg;
    for (int m = 0; m < 4; m++) begin
      gap_pct = gap_mode[m];
      stall_pct = stall_mode[m];
      gap_cfg = $urandom_range(60);
      write_reg(REG_RX_GAP, gap_cfg[CFG_W-1:0]);
      write_reg(REG_TX_GUARD, CFG_W'($urandom_range(60)));
      run_traffic(200, gap_cfg / 4 + 2);
      wait_idle();
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_status
    status_t want;
    status_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[21:0];
      if (expected_status.size() == 0) begin
        $error("status word with no poll outstanding");
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("tx_start",        want.tx_start,        seen.tx_start);
        check_field("tx_start_length", want.tx_start_length, seen.tx_start_length);
        check_field("tx_pending",      want.tx_pending,      seen.tx_pending);
        check_field("rx_arm",          want.rx_arm,          seen.rx_arm);
        check_field("frame_ready",     want.frame_ready,     seen.frame_ready);
        check_field("frame_length",    want.frame_length,    seen.frame_length);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_window_extremes();
    test_idle_patterns();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== uart_idle_gap_framer_tx_sequencer.f =====
design/uigf_pkg.sv
design/uigf_tx_fsm.sv
design/uigf_rx_fsm.sv
design/uart_idle_gap_framer_tx_sequencer.sv
design/uigf_checker.sv
verif/uart_idle_gap_framer_tx_sequencer_tb.sv
